// ===== rtl/core/mhp_pkg.sv =====
// shared types and constants of the multimedia-object header parser
// used by mhp_parse and mot_header_parser; depends on nothing else
package mhp_pkg;

	// summary status codes
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_SHORT      = 3'd1;
	localparam logic [2:0] ST_MISMATCH   = 3'd2;
	localparam logic [2:0] ST_TRUNCATED  = 3'd3;
	localparam logic [2:0] ST_SCRAMBLED  = 3'd4;
	localparam logic [2:0] ST_COMPRESSED = 3'd5;

	// result kinds
	localparam logic KIND_PARAM   = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	// configuration register indexes and reset values
	localparam logic       CFG_SCRAMBLED_IDX  = 1'b0;
	localparam logic       CFG_COMPRESSED_IDX = 1'b1;
	localparam logic [5:0] SCRAMBLED_ID_RST   = 6'd35;
	localparam logic [5:0] COMPRESSED_ID_RST  = 6'd17;

	// header core geometry
	localparam int CORE_BYTES = 7;
	localparam logic [12:0] POS_MAX = 13'h1FFF;

	// one result item
	typedef struct packed {
		logic        kind;
		logic [5:0]  param_id;
		logic [14:0] param_len;
		logic        data_valid;
		logic [7:0]  data_byte;
		logic        param_last;
		logic [27:0] body_size;
		logic [5:0]  content_type;
		logic [8:0]  content_subtype;
		logic [2:0]  status;
		logic        run_last;
	} mhp_res_t;

endpackage

// ===== rtl/core/mhp_parse.sv =====
// header parse state and per-byte decode: core capture, parameter walk, summary
// depends on mhp_pkg
module mhp_parse (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic [7:0]       hdr_byte,
	input  logic             end_of_header,
	input  logic [5:0]       scrambled_id,
	input  logic [5:0]       compressed_id,
	output logic [1:0]       res_n,
	output mhp_pkg::mhp_res_t res_a,
	output mhp_pkg::mhp_res_t res_b
);

	typedef enum logic [2:0] {
		PH_CORE,
		PH_PHDR,
		PH_LEN1,
		PH_LEN2,
		PH_DATA
	} phase_t;

	phase_t      phase_q, phase_n;
	logic [12:0] pos_q, pos_n;
	logic [55:0] core_q, core_n;
	logic [12:0] hlen_q, hlen_n;
	logic [5:0]  cur_q, cur_n;
	logic [14:0] rem_q, rem_n;
	logic [14:0] plen_q, plen_n;
	logic        sup_q, sup_n;
	logic [2:0]  err_q, err_n;

	logic        rec_v;
	logic        rec_dv;
	logic        rec_last;
	logic        len_done;
	logic [13:0] total;
	logic [2:0]  status;
	mhp_pkg::mhp_res_t rec, sum;

	// per-byte decode
	always_comb begin
		phase_n  = phase_q;
		core_n   = core_q;
		hlen_n   = hlen_q;
		cur_n    = cur_q;
		rem_n    = rem_q;
		plen_n   = plen_q;
		sup_n    = sup_q;
		err_n    = err_q;
		rec_v    = 1'b0;
		rec_dv   = 1'b0;
		rec_last = 1'b0;
		len_done = 1'b0;
		if (phase_q == PH_CORE) begin
			// big-endian capture of the seven core bytes
			for (int i = 0; i < mhp_pkg::CORE_BYTES; i++) begin
				if (pos_q == 13'(i))
					core_n[(mhp_pkg::CORE_BYTES - 1 - i) * 8 +: 8] =
						core_q[(mhp_pkg::CORE_BYTES - 1 - i) * 8 +: 8] | hdr_byte;
			end
			if (pos_q >= 13'(mhp_pkg::CORE_BYTES - 1)) begin
				hlen_n  = core_n[27:15];
				phase_n = PH_PHDR;
			end
		end else if (pos_q < hlen_q) begin
			case (phase_q)
				PH_PHDR: begin
					cur_n = hdr_byte[5:0];
					sup_n = 1'b0;
					if (hdr_byte[5:0] == scrambled_id) begin
						sup_n = 1'b1;
						if (err_q == mhp_pkg::ST_OK) err_n = mhp_pkg::ST_SCRAMBLED;
					end else if (hdr_byte[5:0] == compressed_id) begin
						sup_n = 1'b1;
						if (err_q == mhp_pkg::ST_OK) err_n = mhp_pkg::ST_COMPRESSED;
					end
					case (hdr_byte[7:6])
						2'd0: begin
							plen_n   = '0;
							rec_v    = !sup_n;
							rec_last = 1'b1;
						end
						2'd3: phase_n = PH_LEN1;
						default: begin
							plen_n  = (hdr_byte[7:6] == 2'd1) ? 15'd1 : 15'd4;
							rem_n   = plen_n;
							phase_n = PH_DATA;
						end
					endcase
				end
				PH_LEN1: begin
					if (hdr_byte[7]) begin
						plen_n  = {hdr_byte[6:0], 8'h00};
						phase_n = PH_LEN2;
					end else begin
						plen_n   = {8'h00, hdr_byte[6:0]};
						len_done = 1'b1;
					end
				end
				PH_LEN2: begin
					plen_n   = plen_q | {7'h00, hdr_byte};
					len_done = 1'b1;
				end
				default: begin
					rem_n = rem_q - 15'd1;
					if (rem_n == '0) phase_n = PH_PHDR;
					rec_v    = !sup_q;
					rec_dv   = 1'b1;
					rec_last = (rem_n == '0);
				end
			endcase
			// explicit length complete
			if (len_done) begin
				rem_n = plen_n;
				if (plen_n == '0) begin
					phase_n  = PH_PHDR;
					rec_v    = !sup_q;
					rec_last = 1'b1;
				end else begin
					phase_n = PH_DATA;
				end
			end
		end
		pos_n = (pos_q == mhp_pkg::POS_MAX) ? pos_q : pos_q + 13'd1;
	end

	// summary status
	assign total = {1'b0, pos_q} + 14'd1;
	always_comb begin
		if (total < 14'(mhp_pkg::CORE_BYTES))
			status = mhp_pkg::ST_SHORT;
		else if (total != {1'b0, hlen_n})
			status = mhp_pkg::ST_MISMATCH;
		else if (err_n != mhp_pkg::ST_OK)
			status = err_n;
		else if (phase_n == PH_LEN1 || phase_n == PH_LEN2 || phase_n == PH_DATA)
			status = mhp_pkg::ST_TRUNCATED;
		else
			status = mhp_pkg::ST_OK;
	end

	// result assembly
	always_comb begin
		rec            = '0;
		rec.kind       = mhp_pkg::KIND_PARAM;
		rec.param_id   = cur_n;
		rec.param_len  = plen_n;
		rec.data_valid = rec_dv;
		rec.data_byte  = rec_dv ? hdr_byte : 8'h00;
		rec.param_last = rec_last;
		rec.run_last   = !end_of_header;

		sum        = '0;
		sum.kind   = mhp_pkg::KIND_SUMMARY;
		sum.status = status;
		if (status != mhp_pkg::ST_SHORT) begin
			sum.body_size       = core_n[55:28];
			sum.content_type    = core_n[14:9];
			sum.content_subtype = core_n[8:0];
		end
		sum.run_last = 1'b1;

		res_a = rec_v ? rec : sum;
		res_b = sum;
		res_n = 2'(rec_v) + 2'(end_of_header);
	end

	// parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_CORE;
			pos_q   <= '0;
			core_q  <= '0;
			hlen_q  <= '0;
			cur_q   <= '0;
			rem_q   <= '0;
			plen_q  <= '0;
			sup_q   <= 1'b0;
			err_q   <= mhp_pkg::ST_OK;
		end else if (en) begin
			if (end_of_header) begin
				phase_q <= PH_CORE;
				pos_q   <= '0;
				core_q  <= '0;
				hlen_q  <= '0;
				cur_q   <= '0;
				rem_q   <= '0;
				plen_q  <= '0;
				sup_q   <= 1'b0;
				err_q   <= mhp_pkg::ST_OK;
			end else begin
				phase_q <= phase_n;
				pos_q   <= pos_n;
				core_q  <= core_n;
				hlen_q  <= hlen_n;
				cur_q   <= cur_n;
				rem_q   <= rem_n;
				plen_q  <= plen_n;
				sup_q   <= sup_n;
				err_q   <= err_n;
			end
		end
	end

endmodule

// ===== rtl/core/mot_header_parser.sv =====
// mot_header_parser: one header byte per cycle while the result queue has room, input register, decode, result queue
// a byte passes the input register and then the result queue before its first result can be transferred
// throughput: one byte per cycle unless decode waits; a closing byte with a pending record yields two results
// the queue of OUT_DEPTH results decouples the output; decode waits when fewer than two slots are free
// reset clears parse state and queue, ids return to 35 (scrambled) and 17 (compressed)
// depends on mhp_pkg and mhp_parse
module mot_header_parser #(
	parameter int OUT_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] hdr_byte
	input  logic        s_tlast,   // end_of_header
	output logic        m_tvalid,
	input  logic        m_tready,
	// [5:0] param_id, [20:6] param_len, [21] data_valid, [29:22] data_byte,
	// [30] param_last, [58:31] body_size, [64:59] content_type,
	// [73:65] content_subtype, [76:74] status, [79:77] zero
	output logic [79:0] m_tdata,
	output logic        m_tlast,   // run_last
	output logic        m_tuser,   // kind
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [5:0]  cfg_data
);

	localparam int PW = (OUT_DEPTH > 2) ? $clog2(OUT_DEPTH) : 1;
	localparam int CW = $clog2(OUT_DEPTH + 1);

	logic [5:0] scr_id_q, cmp_id_q;
	logic       v_s1;
	logic [7:0] byte_s1;
	logic       eoh_s1;
	logic       proc;
	logic       pop;
	logic [1:0] res_n;
	logic [1:0] push_n;
	mhp_pkg::mhp_res_t res_a, res_b, head;
	mhp_pkg::mhp_res_t q_mem [OUT_DEPTH];
	logic [PW-1:0] wr_q, rd_q, wr1;
	logic [CW-1:0] cnt_q;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		ptr_inc = (p == PW'(OUT_DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	// configuration writes
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scr_id_q <= mhp_pkg::SCRAMBLED_ID_RST;
			cmp_id_q <= mhp_pkg::COMPRESSED_ID_RST;
		end else if (cfg_valid) begin
			if (cfg_index == mhp_pkg::CFG_SCRAMBLED_IDX) scr_id_q <= cfg_data;
			if (cfg_index == mhp_pkg::CFG_COMPRESSED_IDX) cmp_id_q <= cfg_data;
		end
	end

	// input register
	assign proc     = v_s1 && (cnt_q <= CW'(OUT_DEPTH - 2));
	assign s_tready = !v_s1 || proc;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			v_s1 <= 1'b1;
		end else if (proc) begin
			v_s1 <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			eoh_s1  <= s_tlast;
		end
	end

	mhp_parse u_parse (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (proc),
		.hdr_byte      (byte_s1),
		.end_of_header (eoh_s1),
		.scrambled_id  (scr_id_q),
		.compressed_id (cmp_id_q),
		.res_n         (res_n),
		.res_a         (res_a),
		.res_b         (res_b)
	);

	// result queue
	assign push_n = proc ? res_n : 2'd0;
	assign pop    = m_tvalid && m_tready;
	assign wr1    = ptr_inc(wr_q);
	always_ff @(posedge clk) begin
		if (push_n != 2'd0) q_mem[wr_q] <= res_a;
		if (push_n == 2'd2) q_mem[wr1] <= res_b;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push_n == 2'd1) wr_q <= wr1;
			else if (push_n == 2'd2) wr_q <= ptr_inc(wr1);
			if (pop) rd_q <= ptr_inc(rd_q);
			cnt_q <= cnt_q + CW'(push_n) - CW'(pop);
		end
	end

	// output transfer
	assign head     = q_mem[rd_q];
	assign m_tvalid = (cnt_q != '0);
	assign m_tlast  = head.run_last;
	assign m_tuser  = head.kind;
	assign m_tdata  = {3'b000, head.status, head.content_subtype, head.content_type,
		head.body_size, head.param_last, head.data_byte, head.data_valid,
		head.param_len, head.param_id};

endmodule
